/* rtl/kme_pkg.sv */
// Shared types, codes and helper functions for the key matrix emulator.
// No dependencies; every other file in rtl imports this package.
`default_nettype none

package kme_pkg;

    localparam int unsigned NUM_ROWS  = 8;
    localparam int unsigned ROW_W     = 8;
    localparam int unsigned ROW_IDX_W = 3;

    // Request type codes; code 3 is ignored.
    localparam logic [1:0] REQ_SCAN  = 2'd0;
    localparam logic [1:0] REQ_KEY   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // Key action codes; code 3 behaves as hold.
    localparam logic [1:0] ACT_STOP    = 2'd0;
    localparam logic [1:0] ACT_HOLD    = 2'd1;
    localparam logic [1:0] ACT_TRIGGER = 2'd2;

    localparam logic [7:0]           LINES_WRAP = 8'b1000_0001;
    localparam logic [ROW_W-1:0]     POLY_BIT   = 8'h80;
    localparam logic [ROW_IDX_W-1:0] POLY_ROW   = 3'd7;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] scan_lines;
        logic [2:0] key_row;
        logic [7:0] key_mask;
        logic [1:0] key_action;
    } t_request;

    typedef struct packed {
        logic       drive_update;
        logic [7:0] drive_bits;
        logic [2:0] selected_row;
    } t_result;

    // Classification of one scan line pattern.
    typedef struct packed {
        logic                 any_line;
        logic                 narrow;
        logic                 single;
        logic [ROW_IDX_W-1:0] row;
    } t_scan_dec;

    function automatic logic [3:0] count_lines(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'd0, v[i]};
        end
        return n;
    endfunction

    function automatic logic [ROW_IDX_W-1:0] top_line(input logic [7:0] v);
        logic [ROW_IDX_W-1:0] top;
        top = '0;
        for (int i = 0; i < 8; i++) begin
            if (v[i]) begin
                top = ROW_IDX_W'(i);
            end
        end
        return top;
    endfunction

endpackage

`default_nettype wire

/* rtl/key_matrix_emulator.sv */
// Top level of the key matrix emulator: request register, scan decoder,
// matrix state and result register. Depends on kme_pkg, kme_scan_decode, kme_matrix.
//
// Usage:
//   A request beat is taken at each rising edge with start high and busy
//   low. busy is always low, so one beat may be offered in every cycle.
//   Every request gives exactly one result beat: o_strobe is high for one
//   cycle with o_result valid. A beat taken is held in the request register,
//   worked out from the matrix state during the next cycle and registered in
//   the result register, which o_strobe then shows; one beat per cycle is
//   sustained.
//   The rate is set by the single read-modify-write of the row masks that
//   sits between the request register and the result register.
//   The receiver cannot stall: a result that is not taken in its strobe
//   cycle is gone.
//   i_cfg_we with i_cfg_wdata writes the polyphony bit, which is ORed into
//   bit 7 whenever row 7 is driven; write it only while no beat is in flight.
//   Synchronous reset clears all rows, trigger and release masks, the
//   polyphony bit and the pipeline valid flags.
`default_nettype none

module key_matrix_emulator (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire kme_pkg::t_request  i_req,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_wdata,
    output logic                    o_strobe,
    output kme_pkg::t_result        o_result
);
    import kme_pkg::*;

    logic      r_poly;
    logic      r_req_valid;
    t_request  r_req;
    logic      r_out_valid;
    t_result   r_out;
    t_result   n_out;
    t_scan_dec w_dec;
    logic [7:0] w_row_bits;

    assign busy     = 1'b0;
    assign o_strobe = r_out_valid;
    assign o_result = r_out;

    kme_scan_decode u_decode (
        .i_lines (r_req.scan_lines),
        .o_dec   (w_dec)
    );

    kme_matrix u_matrix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_req_valid),
        .i_req      (r_req),
        .i_dec      (w_dec),
        .o_row_bits (w_row_bits)
    );

    always_comb begin
        n_out = '0;
        if ((r_req.req_type == REQ_SCAN) && w_dec.any_line) begin
            n_out.drive_update = 1'b1;
            // Three or more active lines pull every return line low.
            if (w_dec.narrow) begin
                n_out.drive_bits   = w_row_bits;
                n_out.selected_row = w_dec.row;
                if ((w_dec.row == POLY_ROW) && r_poly) begin
                    n_out.drive_bits = w_row_bits | POLY_BIT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly      <= 1'b0;
            r_req_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_poly <= i_cfg_wdata;
            end
            r_req_valid <= start && !busy;
            r_out_valid <= r_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req <= i_req;
        end
        r_out <= n_out;
    end

endmodule

`default_nettype wire

/* rtl/kme_scan_decode.sv */
// Scan line decoder: counts active lines and picks the row to drive.
// Depends on kme_pkg.
`default_nettype none

module kme_scan_decode (
    input  wire logic [7:0]        i_lines,
    output kme_pkg::t_scan_dec     o_dec
);
    import kme_pkg::*;

    logic [3:0] w_count;

    always_comb begin
        w_count        = count_lines(i_lines);
        o_dec.any_line = (i_lines != 8'd0);
        o_dec.narrow   = (w_count <= 4'd2);
        o_dec.single   = (w_count == 4'd1);
        // Lines 0 and 7 together wrap around to row 0.
        o_dec.row      = (i_lines == LINES_WRAP) ? '0 : top_line(i_lines);
    end

endmodule

`default_nettype wire

/* rtl/kme_matrix.sv */
// Pressed, trigger and release masks for the eight rows, with their update
// on scan, key and clear beats. Depends on kme_pkg.
`default_nettype none

module kme_matrix (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire kme_pkg::t_request  i_req,
    input  wire kme_pkg::t_scan_dec i_dec,
    output logic [7:0]              o_row_bits
);
    import kme_pkg::*;

    logic [ROW_W-1:0] r_pressed [NUM_ROWS];
    logic [ROW_W-1:0] r_trigger [NUM_ROWS];
    logic [ROW_W-1:0] r_release [NUM_ROWS];
    logic [ROW_W-1:0] n_pressed [NUM_ROWS];
    logic [ROW_W-1:0] n_trigger [NUM_ROWS];
    logic [ROW_W-1:0] n_release [NUM_ROWS];

    logic w_is_scan;
    logic w_retire;

    assign w_is_scan  = (i_req.req_type == REQ_SCAN);
    // Only a scan with exactly one active line ages the trigger masks.
    assign w_retire   = i_valid && w_is_scan && i_dec.single;
    assign o_row_bits = r_pressed[i_dec.row];

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            n_pressed[r] = r_pressed[r];
            n_trigger[r] = r_trigger[r];
            n_release[r] = r_release[r];
            if (w_retire && (i_dec.row == ROW_IDX_W'(r))) begin
                n_pressed[r] = r_pressed[r] & ~r_release[r];
                n_release[r] = r_trigger[r];
                n_trigger[r] = '0;
            end
            if (i_valid && (i_req.req_type == REQ_KEY) &&
                (i_req.key_row == ROW_IDX_W'(r))) begin
                if (i_req.key_action == ACT_STOP) begin
                    n_pressed[r] = r_pressed[r] & ~i_req.key_mask;
                end else begin
                    n_pressed[r] = r_pressed[r] | i_req.key_mask;
                    if (i_req.key_action == ACT_TRIGGER) begin
                        n_trigger[r] = r_trigger[r] | i_req.key_mask;
                    end
                end
            end
            if (i_valid && (i_req.req_type == REQ_CLEAR)) begin
                n_pressed[r] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            if (!i_rst_n) begin
                r_pressed[r] <= '0;
                r_trigger[r] <= '0;
                r_release[r] <= '0;
            end else begin
                r_pressed[r] <= n_pressed[r];
                r_trigger[r] <= n_trigger[r];
                r_release[r] <= n_release[r];
            end
        end
    end

endmodule

`default_nettype wire

/* verif/tb_key_matrix_emulator.sv */
// Self-checking testbench for key_matrix_emulator: a directed table, then random phases
// under both polyphony settings, checked against typed rows or a behavioral matrix model.
// Depends on kme_pkg and the key_matrix_emulator RTL.

module tb_key_matrix_emulator;

    import kme_pkg::*;

    // Codes that the package leaves unnamed.
    localparam logic [1:0] REQ_IGNORED    = 2'd3;
    localparam logic [1:0] ACT_HOLD_ALIAS = 2'd3;

    localparam int PHASES          = 4;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int QUIET_LIMIT     = 100;
    localparam int PRINT_LIMIT     = 40;

    typedef struct packed {
        t_request req;
        logic     typed;
        t_result  want;
    } t_vector;

    localparam int NUM_DIRECTED = 25;

    localparam t_result NO_DRIVE = '{1'b0, 8'h00, 3'd0};

    // Rows with typed = 0 take their expectation from the model below.
    localparam t_vector DIRECTED [NUM_DIRECTED] = '{
        '{'{REQ_SCAN, 8'h00, 3'd0, 8'h00, ACT_STOP}, 1'b1, NO_DRIVE},
        '{'{REQ_SCAN, 8'h80, 3'd0, 8'h00, ACT_STOP}, 1'b1, '{1'b1, 8'h00, 3'd7}},
        '{'{REQ_KEY, 8'h00, 3'd0, 8'hFF, ACT_HOLD}, 1'b1, NO_DRIVE},
        '{'{REQ_SCAN, 8'h01, 3'd0, 8'h00, ACT_STOP}, 1'b1, '{1'b1, 8'hFF, 3'd0}},
        '{'{REQ_SCAN, 8'h81, 3'd0, 8'h00, ACT_STOP}, 1'b1, '{1'b1, 8'hFF, 3'd0}},
        '{'{REQ_SCAN, 8'hFF, 3'd7, 8'hFF, ACT_HOLD_ALIAS}, 1'b1, '{1'b1, 8'h00, 3'd0}},
        '{'{REQ_KEY, 8'h00, 3'd7, 8'h55, ACT_TRIGGER}, 1'b1, NO_DRIVE},
        '{'{REQ_SCAN, 8'hC0, 3'd0, 8'h00, ACT_STOP}, 1'b1, '{1'b1, 8'h55, 3'd7}},
        '{'{REQ_SCAN, 8'h80, 3'd0, 8'h00, ACT_STOP}, 1'b1, '{1'b1, 8'h55, 3'd7}},
        '{'{REQ_SCAN, 8'h80, 3'd0, 8'h00, ACT_STOP}, 1'b1, '{1'b1, 8'h55, 3'd7}},
        '{'{REQ_SCAN, 8'h80, 3'd0, 8'h00, ACT_STOP}, 1'b1, '{1'b1, 8'h00, 3'd7}},
        '{'{REQ_KEY, 8'h00, 3'd3, 8'hAA, ACT_HOLD_ALIAS}, 1'b1, NO_DRIVE},
        '{'{REQ_SCAN, 8'h08, 3'd0, 8'h00, ACT_STOP}, 1'b1, '{1'b1, 8'hAA, 3'd3}},
        '{'{REQ_KEY, 8'h00, 3'd3, 8'h0F, ACT_STOP}, 1'b1, NO_DRIVE},
        '{'{REQ_SCAN, 8'h0C, 3'd0, 8'h00, ACT_STOP}, 1'b1, '{1'b1, 8'hA0, 3'd3}},
        '{'{REQ_KEY, 8'h00, 3'd5, 8'hFF, ACT_HOLD}, 1'b1, NO_DRIVE},
        '{'{REQ_CLEAR, 8'hFF, 3'd7, 8'hFF, ACT_TRIGGER}, 1'b1, NO_DRIVE},
        '{'{REQ_SCAN, 8'h20, 3'd0, 8'h00, ACT_STOP}, 1'b1, '{1'b1, 8'h00, 3'd5}},
        '{'{REQ_IGNORED, 8'hFF, 3'd7, 8'hFF, ACT_HOLD_ALIAS}, 1'b1, NO_DRIVE},
        '{'{REQ_KEY, 8'h00, 3'd6, 8'h01, ACT_TRIGGER}, 1'b0, NO_DRIVE},
        '{'{REQ_CLEAR, 8'h00, 3'd0, 8'h00, ACT_STOP}, 1'b0, NO_DRIVE},
        '{'{REQ_KEY, 8'h00, 3'd6, 8'h03, ACT_HOLD}, 1'b0, NO_DRIVE},
        '{'{REQ_SCAN, 8'h40, 3'd0, 8'h00, ACT_STOP}, 1'b0, NO_DRIVE},
        '{'{REQ_SCAN, 8'h40, 3'd0, 8'h00, ACT_STOP}, 1'b0, NO_DRIVE},
        '{'{REQ_SCAN, 8'h40, 3'd0, 8'h00, ACT_STOP}, 1'b0, NO_DRIVE}
    };

    logic     i_clk;
    logic     i_rst_n     = 1'b0;
    logic     start       = 1'b0;
    logic     busy;
    t_request i_req       = '0;
    logic     i_cfg_we    = 1'b0;
    logic     i_cfg_wdata = 1'b0;
    logic     o_strobe;
    t_result  o_result;

    key_matrix_emulator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Model of the key matrix.
    logic [7:0] held_keys [8];
    logic [7:0] trig_mask [8];
    logic [7:0] rel_mask  [8];
    logic       poly_key;

    t_result expected_drives [$];
    t_result oldest_drive;
    int      mismatch_count = 0;
    int      quiet_cycles   = 0;
    int      burst_left     = 0;

    function automatic t_result matrix_response(input t_request r);
        t_result    res;
        logic [2:0] row;
        int         lines_on;
        res = '0;
        case (r.req_type)
            REQ_SCAN: begin
                lines_on = $countones(r.scan_lines);
                if (lines_on != 0) begin
                    res.drive_update = 1'b1;
                    if (lines_on <= 2) begin
                        row = '0;
                        for (int i = 0; i < 8; i++) begin
                            if (r.scan_lines[i]) row = 3'(i);
                        end
                        if (r.scan_lines == LINES_WRAP) row = '0;
                        res.drive_bits = held_keys[row];
                        if (row == POLY_ROW && poly_key) res.drive_bits |= POLY_BIT;
                        res.selected_row = row;
                        // A single-line scan ages the row: released keys drop and
                        // triggered keys move into the release mask.
                        if (lines_on == 1) begin
                            held_keys[row] = held_keys[row] & ~rel_mask[row];
                            rel_mask[row]  = trig_mask[row];
                            trig_mask[row] = '0;
                        end
                    end
                end
            end
            REQ_KEY: begin
                if (r.key_action == ACT_STOP) begin
                    held_keys[r.key_row] &= ~r.key_mask;
                end else begin
                    held_keys[r.key_row] |= r.key_mask;
                    if (r.key_action == ACT_TRIGGER) trig_mask[r.key_row] |= r.key_mask;
                end
            end
            REQ_CLEAR: begin
                for (int i = 0; i < 8; i++) held_keys[i] = '0;
            end
            default: ;
        endcase
        return res;
    endfunction

    // Mostly key presses and one- or two-line scans, so that triggered keys age
    // through the release mask; the rest is clears, empty and wide scans and unused codes.
    function automatic t_request random_request();
        t_request r;
        int       pick;
        int       shape;
        r.scan_lines = 8'($urandom);
        r.key_row    = 3'($urandom);
        r.key_mask   = 8'($urandom);
        r.key_action = 2'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 48) begin
            r.req_type = REQ_SCAN;
            shape = $urandom_range(0, 99);
            if (shape < 55) begin
                r.scan_lines = 8'd1 << $urandom_range(0, 7);
            end else if (shape < 75) begin
                r.scan_lines = (8'd1 << $urandom_range(0, 7)) | (8'd1 << $urandom_range(0, 7));
            end else if (shape < 80) begin
                r.scan_lines = LINES_WRAP;
            end else if (shape < 85) begin
                r.scan_lines = '0;
            end
        end else if (pick < 90) begin
            r.req_type = REQ_KEY;
        end else if (pick < 96) begin
            r.req_type = REQ_CLEAR;
        end else begin
            r.req_type = REQ_IGNORED;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_LIMIT) $display("mismatch: %s", what);
        mismatch_count++;
    endtask

    // Offers one request beat, with a random gap at the start of each burst.
    task automatic offer(input t_request r, input logic typed, input t_result want);
        int      gap;
        t_result predicted;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                start <= 1'b0;
                i_req <= random_request();
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        predicted = matrix_response(r);
        expected_drives.push_back(typed ? want : predicted);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_drives.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_poly(input logic value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        poly_key = value;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                if (expected_drives.size() == 0) begin
                    report_mismatch("result beat with no expectation waiting");
                end else begin
                    oldest_drive = expected_drives.pop_front();
                    if (o_result.drive_update !== oldest_drive.drive_update)
                        report_mismatch($sformatf("drive_update got %0b want %0b",
                            o_result.drive_update, oldest_drive.drive_update));
                    if (o_result.drive_bits !== oldest_drive.drive_bits)
                        report_mismatch($sformatf("drive_bits got %02h want %02h",
                            o_result.drive_bits, oldest_drive.drive_bits));
                    if (o_result.selected_row !== oldest_drive.selected_row)
                        report_mismatch($sformatf("selected_row got %0d want %0d",
                            o_result.selected_row, oldest_drive.selected_row));
                end
            end
            if ((start && !busy) || o_strobe) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        int       sent;
        t_request r;
        for (int i = 0; i < 8; i++) begin
            held_keys[i] = '0;
            trig_mask[i] = '0;
            rel_mask[i]  = '0;
        end
        poly_key = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_poly(1'b0);

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            offer(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].want);
        end

        // Phases alternate the polyphony bit; it is only written with nothing in flight.
        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            write_poly(~phase[0]);
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                r = random_request();
                offer(r, 1'b0, NO_DRIVE);
                if (r.req_type != REQ_IGNORED) sent++;
            end
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
